@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed: label");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed: label");
`endif

@@ rtl/core/ipv4ft_pkg.sv @@
// Package of the IPv4 fragment tracker: codes, widths and defaults.
`default_nettype none
package ipv4ft_pkg;
   localparam int unsigned TableEntriesDefault = 256;
   localparam logic [15:0] TimeoutReset = 16'd500;

   localparam logic [1:0] REQ_MAIN   = 2'd0;
   localparam logic [1:0] REQ_LATE   = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [2:0] ACT_PASS  = 3'd0;
   localparam logic [2:0] ACT_ABORT = 3'd1;
   localparam logic [2:0] ACT_DROP  = 3'd2;
   localparam logic [2:0] ACT_QUEUE = 3'd3;
   localparam logic [2:0] ACT_TX    = 3'd4;
   localparam logic [2:0] ACT_FWD   = 3'd5;
   localparam logic [2:0] ACT_TICK  = 3'd6;

   // Memory word: tag, addresses, rule mark, age.
   localparam int unsigned EntryWidth = 24 + 64 + 1 + 16;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_READ  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;
endpackage
`default_nettype wire

@@ rtl/core/ipv4ft_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module ipv4ft_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/core/ipv4_fragment_tracker_unit.sv @@
// Top level of the IPv4 fragment tracker: flow table walker and packet decisions.
`default_nettype none
// Flow entries sit in one RAM; per-entry valid bits are flip-flops cleared by
// reset, so no clearing pass is needed. A tick, a late fragment with a good
// header, or an IPv4 main-path fragment walks all TABLE_ENTRIES slots through
// the single RAM read port, one slot a cycle, with the write-back of a tick's
// aged entry in the cycle its data arrives. Such a request passes through a
// read state (ST_READ), the walk (ST_CHECK), a decision state (ST_WRITE) and
// an output state (ST_OUT) before its result shows; a request that needs no
// table lookup (abort, pass, unfragmented, unused type) goes straight to
// ST_OUT. The result is held in an output register, and the next beat is
// taken in the cycle after the result has been delivered, so no new request
// is taken while one is in flight or its result waits. The rule mark of a
// first fragment is written back in the output cycle. The timeout register
// should be written only while no request is in flight.
module ipv4_fragment_tracker_unit
   import ipv4ft_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_timeout_ticks,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_req_type,
   input  wire logic        req_header_ok,
   input  wire logic        req_is_ipv4,
   input  wire logic [7:0]  req_proto,
   input  wire logic [15:0] req_ip_ident,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [12:0] req_frag_offset,
   input  wire logic        req_more_frags,
   input  wire logic        req_queue_available,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_action,
   output logic             rsp_reorder_signal,
   output logic             rsp_forwarded_first,
   output logic [8:0]       rsp_expired_unmatched
);
   localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

   state_type state_ff, state_in;
   logic [15:0] timeout_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [1:0]  type_ff;
   logic [23:0] tag_ff;
   logic [63:0] addrs_ff;
   logic        first_ff, qavail_ff;
   logic [IdxW-1:0] scan_ff, scan_in;     // address being read
   logic [IdxW-1:0] chk_ff, chk_in;       // address whose data is on rd_data
   logic        found_ff, found_in, hitrule_ff, hitrule_in;
   logic [IdxW-1:0] hit_ff, hit_in;
   logic        free_ff, free_in;
   logic [IdxW-1:0] freeidx_ff, freeidx_in;
   logic [8:0]  exp_ff, exp_in;
   logic        last_ff, last_in;
   logic        wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [EntryWidth-1:0] wr_data, rd_data;
   logic [2:0]  act_in;
   logic        reo_in, fwd_in;

   logic [23:0] rd_tag;
   logic [63:0] rd_addrs;
   logic        rd_rule;
   logic [15:0] rd_age, age_inc, tmo;
   assign {rd_tag, rd_addrs, rd_rule, rd_age} = rd_data;
   assign age_inc = (rd_age == 16'hFFFF) ? rd_age : rd_age + 16'd1;
   assign tmo = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;

   assign req_ready = state_ff == ST_IDLE && !rsp_valid;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      scan_in = scan_ff;
      chk_in = chk_ff;
      found_in = found_ff;
      hitrule_in = hitrule_ff;
      hit_in = hit_ff;
      free_in = free_ff;
      freeidx_in = freeidx_ff;
      exp_in = exp_ff;
      last_in = last_ff;
      wr_en = 1'b0;
      wr_addr = chk_ff;
      wr_data = {rd_tag, rd_addrs, rd_rule, age_inc};
      act_in = ACT_PASS;
      reo_in = 1'b0;
      fwd_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            found_in = 1'b0;
            free_in = 1'b0;
            exp_in = '0;
            last_in = 1'b0;
            if (req_valid && req_ready) begin
               if (req_req_type == REQ_TICK || (req_req_type == REQ_LATE && req_header_ok)
                   || (req_req_type == REQ_MAIN && req_header_ok && req_is_ipv4
                       && (req_frag_offset != 13'd0 || req_more_frags))) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_READ: begin
            // Address 0 is being read; data appears next cycle.
            chk_in = scan_ff;
            scan_in = scan_ff + IdxW'(1);
            last_in = scan_ff == LastIdx;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (type_ff == REQ_TICK) begin
               if (valid_ff[chk_ff]) begin
                  wr_en = 1'b1;
                  if (age_inc >= tmo) begin
                     valid_in[chk_ff] = 1'b0;
                     if (!rd_rule && exp_ff != 9'd511) exp_in = exp_ff + 9'd1;
                  end
               end
            end else begin
               if (valid_ff[chk_ff] && !found_ff && rd_tag == tag_ff && rd_addrs == addrs_ff) begin
                  found_in = 1'b1;
                  hit_in = chk_ff;
                  hitrule_in = rd_rule;
               end
               if (!valid_ff[chk_ff] && !free_ff) begin
                  free_in = 1'b1;
                  freeidx_in = chk_ff;
               end
            end
            chk_in = scan_ff;
            scan_in = scan_ff + IdxW'(1);
            last_in = scan_ff == LastIdx;
            if (last_ff) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // Decision and table update for a request once the walk is over.
      if (state_ff == ST_WRITE) begin
         if (type_ff == REQ_TICK) begin
            act_in = ACT_TICK;
         end else if (type_ff == REQ_LATE) begin
            act_in = (found_ff && hitrule_ff) ? ACT_FWD : ACT_DROP;
         end else if (!first_ff) begin
            if (!found_ff) begin
               if (free_ff) begin
                  wr_en = 1'b1;
                  wr_addr = freeidx_ff;
                  wr_data = {tag_ff, addrs_ff, 1'b0, 16'd0};
                  valid_in[freeidx_ff] = 1'b1;
                  act_in = qavail_ff ? ACT_QUEUE : ACT_DROP;
               end else begin
                  act_in = ACT_DROP;
               end
            end else begin
               act_in = hitrule_ff ? ACT_TX : (qavail_ff ? ACT_QUEUE : ACT_DROP);
            end
         end else begin
            act_in = ACT_TX;
            if (found_ff) begin
               fwd_in = 1'b1;
               if (!hitrule_ff) begin
                  // Only the rule mark changes; the age of this entry stays put.
                  reo_in = 1'b1;
               end
            end else if (free_ff) begin
               wr_en = 1'b1;
               wr_addr = freeidx_ff;
               wr_data = {tag_ff, addrs_ff, 1'b1, 16'd0};
               valid_in[freeidx_ff] = 1'b1;
               fwd_in = 1'b1;
            end else begin
               act_in = ACT_DROP;
            end
         end
      end
   end

   // Age of a hit entry is needed for the rule-mark write, so keep it.
   logic [15:0] hitage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         timeout_ff <= TimeoutReset;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_wr_en) timeout_ff <= csr_timeout_ticks;
         if (state_ff == ST_OUT) rsp_valid <= 1'b1;
         else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      end
   end

   // Rule-mark write of a first fragment: separate port cycle in ST_OUT.
   logic        mark_ff;
   logic [IdxW-1:0] mark_idx_ff;
   logic [EntryWidth-1:0] mark_data;
   assign mark_data = {tag_ff, addrs_ff, 1'b1, hitage_ff};

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff <= req_req_type;
         tag_ff <= {req_proto, req_ip_ident};
         addrs_ff <= {req_src_addr, req_dst_addr};
         first_ff <= req_frag_offset == 13'd0;
         qavail_ff <= req_queue_available;
         rsp_action <= ((req_req_type == REQ_MAIN || req_req_type == REQ_LATE)
                        && !req_header_ok) ? ACT_ABORT
                       : (req_req_type == REQ_MAIN && req_is_ipv4) ? ACT_TX : ACT_PASS;
         rsp_reorder_signal <= 1'b0;
         rsp_forwarded_first <= 1'b0;
         rsp_expired_unmatched <= '0;
      end
      if (state_ff == ST_WRITE) begin
         rsp_action <= act_in;
         rsp_reorder_signal <= reo_in;
         rsp_forwarded_first <= fwd_in;
         rsp_expired_unmatched <= (type_ff == REQ_TICK) ? exp_ff : 9'd0;
      end
      mark_ff <= state_ff == ST_WRITE && reo_in;
      mark_idx_ff <= hit_ff;
      scan_ff <= scan_in;
      chk_ff <= chk_in;
      found_ff <= found_in;
      hitrule_ff <= hitrule_in;
      hit_ff <= hit_in;
      if (state_ff == ST_CHECK && found_in && !found_ff) hitage_ff <= rd_age;
      free_ff <= free_in;
      freeidx_ff <= freeidx_in;
      exp_ff <= exp_in;
      last_ff <= last_in;
   end

   // The RAM write port is shared: the rule-mark write lands in ST_OUT, when
   // nothing else writes.
   logic        ram_we;
   logic [IdxW-1:0] ram_wa;
   logic [EntryWidth-1:0] ram_wd;
   assign ram_we = wr_en | mark_ff;
   assign ram_wa = mark_ff ? mark_idx_ff : wr_addr;
   assign ram_wd = mark_ff ? mark_data : wr_data;

   ipv4ft_ram #(.Width(EntryWidth), .Depth(TABLE_ENTRIES)) u_ram (
      .clock, .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd), .rd_addr(scan_ff),
      .rd_data
   );
endmodule
`default_nettype wire

@@ rtl/core/ipv4ft_checker.sv @@
// Port-level checker of the IPv4 fragment tracker, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ipv4ft_checker
   import ipv4ft_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_action,
   input wire logic       rsp_reorder_signal,
   input wire logic       rsp_forwarded_first,
   input wire logic [8:0] rsp_expired_unmatched
);
   `CHK_IMPL(a_no_accept_while_full, clock, reset, rsp_valid, !req_ready)
   `CHK_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_action))
   `CHK_IMPL(a_reorder_is_tx, clock, reset, rsp_valid && rsp_reorder_signal,
             rsp_forwarded_first && rsp_action == ACT_TX)
   `CHK_IMPL(a_expired_on_tick, clock, reset, rsp_valid && rsp_expired_unmatched != 9'd0,
             rsp_action == ACT_TICK)
endmodule

bind ipv4_fragment_tracker_unit ipv4ft_checker u_ipv4ft_checker (.*);
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench of the IPv4 fragment tracker with its own flow table predictor.
`timescale 1ns / 100ps
module testbench
   import ipv4ft_pkg::*;
();

   localparam int unsigned Slots = 256;
   localparam int unsigned DrainCycles = 300;

   typedef struct {
      logic [1:0]  kind;
      logic        header_ok;
      logic        is_ipv4;
      logic [7:0]  proto;
      logic [15:0] ip_ident;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [12:0] frag_offset;
      logic        more_frags;
      logic        queue_available;
   } packet_type;

   typedef struct {
      logic [2:0] action;
      logic       reorder;
      logic       fwd_first;
      logic [8:0] expired;
   } decision_type;

   class flow_decision_board;
      bit          slot_used[Slots];
      logic [63:0] slot_addrs[Slots];
      logic [23:0] slot_tag[Slots];
      bit          slot_rule[Slots];
      logic [15:0] slot_age[Slots];
      logic [15:0] timeout;
      decision_type pending[$];
      int          errors;

      function void clear();
         foreach (slot_used[i]) slot_used[i] = 0;
         timeout = TimeoutReset;
         pending.delete();
         errors = 0;
      endfunction

      function int lookup(logic [23:0] tag, logic [63:0] addrs);
         for (int i = 0; i < Slots; i++)
            if (slot_used[i] && slot_tag[i] == tag && slot_addrs[i] == addrs) return i;
         return -1;
      endfunction

      function bit claim(logic [23:0] tag, logic [63:0] addrs, bit rule);
         for (int i = 0; i < Slots; i++)
            if (!slot_used[i]) begin
               slot_used[i] = 1;
               slot_tag[i] = tag;
               slot_addrs[i] = addrs;
               slot_rule[i] = rule;
               slot_age[i] = '0;
               return 1;
            end
         return 0;
      endfunction

      function void note_packet(packet_type p);
         decision_type d;
         logic [23:0] tag;
         logic [63:0] addrs;
         logic [16:0] limit;
         int idx;
         tag = {p.proto, p.ip_ident};
         addrs = {p.src_addr, p.dst_addr};
         d = '{ACT_PASS, 1'b0, 1'b0, 9'd0};
         limit = (timeout == 0) ? 17'd1 : {1'b0, timeout};
         if (p.kind == REQ_TICK) begin
            for (int i = 0; i < Slots; i++) begin
               if (!slot_used[i]) continue;
               if (slot_age[i] != 16'hFFFF) slot_age[i]++;
               if ({1'b0, slot_age[i]} >= limit) begin
                  slot_used[i] = 0;
                  if (!slot_rule[i] && d.expired != 9'h1FF) d.expired++;
               end
            end
            d.action = ACT_TICK;
         end else if (p.kind == REQ_LATE) begin
            if (!p.header_ok) d.action = ACT_ABORT;
            else begin
               idx = lookup(tag, addrs);
               d.action = (idx < 0 || !slot_rule[idx]) ? ACT_DROP : ACT_FWD;
            end
         end else if (p.kind == REQ_MAIN) begin
            if (!p.header_ok) d.action = ACT_ABORT;
            else if (!p.is_ipv4) d.action = ACT_PASS;
            else if (p.frag_offset != 0) begin
               idx = lookup(tag, addrs);
               if (idx < 0) begin
                  if (!claim(tag, addrs, 0)) d.action = ACT_DROP;
                  else d.action = p.queue_available ? ACT_QUEUE : ACT_DROP;
               end else if (!slot_rule[idx]) begin
                  d.action = p.queue_available ? ACT_QUEUE : ACT_DROP;
               end else begin
                  d.action = ACT_TX;
               end
            end else if (p.more_frags) begin
               idx = lookup(tag, addrs);
               d.action = ACT_TX;
               if (idx >= 0) begin
                  if (!slot_rule[idx]) begin
                     slot_rule[idx] = 1;
                     d.reorder = 1;
                  end
                  d.fwd_first = 1;
               end else if (claim(tag, addrs, 1)) begin
                  d.fwd_first = 1;
               end else begin
                  d.action = ACT_DROP;
               end
            end else begin
               d.action = ACT_TX;
            end
         end
         pending.push_back(d);
      endfunction

      function void check_decision(decision_type got);
         decision_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat, action %0d", $time, got.action);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.action !== want.action) begin
            $display("%0t: action expected %0d, got %0d", $time, want.action, got.action);
            errors++;
         end
         if (got.reorder !== want.reorder) begin
            $display("%0t: reorder expected %0b, got %0b", $time, want.reorder, got.reorder);
            errors++;
         end
         if (got.fwd_first !== want.fwd_first) begin
            $display("%0t: forwarded_first expected %0b, got %0b", $time, want.fwd_first,
                     got.fwd_first);
            errors++;
         end
         if (got.expired !== want.expired) begin
            $display("%0t: expired_unmatched expected %0d, got %0d", $time, want.expired,
                     got.expired);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_timeout_ticks;
   logic        req_valid;
   logic        req_ready;
   packet_type  pkt;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_action;
   logic        rsp_reorder_signal;
   logic        rsp_forwarded_first;
   logic [8:0]  rsp_expired_unmatched;
   bit          steady;

   flow_decision_board board;
   packet_type flow_keys[8];

   ipv4_fragment_tracker_unit u_top (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_timeout_ticks(csr_timeout_ticks),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_req_type(pkt.kind),
      .req_header_ok(pkt.header_ok),
      .req_is_ipv4(pkt.is_ipv4),
      .req_proto(pkt.proto),
      .req_ip_ident(pkt.ip_ident),
      .req_src_addr(pkt.src_addr),
      .req_dst_addr(pkt.dst_addr),
      .req_frag_offset(pkt.frag_offset),
      .req_more_frags(pkt.more_frags),
      .req_queue_available(pkt.queue_available),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_action(rsp_action),
      .rsp_reorder_signal(rsp_reorder_signal),
      .rsp_forwarded_first(rsp_forwarded_first),
      .rsp_expired_unmatched(rsp_expired_unmatched)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_packet(pkt);
         if (rsp_valid && rsp_ready)
            board.check_decision('{rsp_action, rsp_reorder_signal, rsp_forwarded_first,
                                   rsp_expired_unmatched});
      end
   end

   // Between beats the receiver keeps ready low for a random gap, or not at all while steady is set.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(17);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send(packet_type p);
      int gap;
      gap = steady ? 0 : $urandom_range(17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pkt <= p;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic set_timeout(logic [15:0] ticks);
      drain();
      csr_timeout_ticks <= ticks;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.timeout = ticks;
   endtask

   function automatic packet_type make(logic [1:0] kind, int key, logic [12:0] off, bit mf,
                                       bit qa, bit ok = 1, bit v4 = 1);
      packet_type p;
      p = flow_keys[key];
      p.kind = kind;
      p.header_ok = ok;
      p.is_ipv4 = v4;
      p.frag_offset = off;
      p.more_frags = mf;
      p.queue_available = qa;
      return p;
   endfunction

   function automatic void new_keys();
      foreach (flow_keys[i]) begin
         flow_keys[i].proto = 8'($urandom);
         flow_keys[i].ip_ident = 16'($urandom);
         flow_keys[i].src_addr = $urandom;
         flow_keys[i].dst_addr = $urandom;
      end
   endfunction

   function automatic packet_type random_packet();
      packet_type p;
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         p.proto = 8'($urandom);
         p.ip_ident = 16'($urandom);
         p.src_addr = $urandom;
         p.dst_addr = $urandom;
      end else begin
         p = flow_keys[$urandom_range(7)];
      end
      roll = $urandom_range(99);
      p.kind = roll < 58 ? REQ_MAIN : roll < 80 ? REQ_LATE : roll < 97 ? REQ_TICK : REQ_UNUSED;
      p.header_ok = $urandom_range(99) < 93;
      p.is_ipv4 = $urandom_range(99) < 95;
      p.frag_offset = $urandom_range(99) < 45 ? 13'd0 : 13'($urandom_range(8191, 1));
      p.more_frags = 1'($urandom);
      p.queue_available = $urandom_range(99) < 80;
      return p;
   endfunction

   initial begin
      packet_type p;
      board = new();
      board.clear();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_timeout_ticks = '0;
      req_valid = 1'b0;
      pkt = '{default: '0};
      steady = 0;
      new_keys();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: each decision path with a free table, then the field extremes.
      send(make(REQ_MAIN, 0, 0, 0, 1, 0));
      send(make(REQ_MAIN, 0, 0, 0, 1, 1, 0));
      send(make(REQ_MAIN, 0, 0, 0, 1));
      send(make(REQ_MAIN, 1, 13'd8191, 1, 1));
      send(make(REQ_MAIN, 1, 13'd1, 0, 1));
      send(make(REQ_MAIN, 1, 13'd5, 0, 0));
      send(make(REQ_LATE, 1, 0, 0, 1));
      send(make(REQ_MAIN, 1, 0, 1, 1));
      send(make(REQ_MAIN, 1, 0, 1, 1));
      send(make(REQ_MAIN, 1, 13'd7, 1, 0));
      send(make(REQ_LATE, 1, 0, 0, 1));
      send(make(REQ_LATE, 1, 0, 0, 1, 0));
      send(make(REQ_LATE, 2, 0, 0, 1));
      send(make(REQ_MAIN, 3, 0, 1, 0));
      send(make(REQ_MAIN, 4, 13'd100, 0, 0));
      send(make(REQ_UNUSED, 4, 0, 0, 1));
      send(make(REQ_UNUSED, 4, 0, 0, 1, 0));
      send(make(REQ_TICK, 0, 0, 0, 0, 0, 0));
      p = '{REQ_MAIN, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            13'h1FFF, 1'b1, 1'b1};
      send(p);
      p = '{REQ_MAIN, 1'b1, 1'b1, 8'h00, 16'h0000, 32'h0, 32'h0, 13'h0, 1'b1, 1'b1};
      send(p);

      // Fill the table with new flows, then one more of each kind finds it full.
      steady = 1;
      for (int i = 0; i < Slots; i++) begin
         p = random_packet();
         p.kind = REQ_MAIN;
         p.header_ok = 1;
         p.is_ipv4 = 1;
         p.frag_offset = 13'($urandom_range(8191, 1));
         p.ip_ident = 16'(i);
         send(p);
      end
      send(make(REQ_MAIN, 5, 0, 1, 1));
      send(make(REQ_MAIN, 6, 13'd9, 0, 1));
      steady = 0;
      set_timeout(16'd1);
      send(make(REQ_TICK, 0, 0, 0, 1));
      set_timeout(16'd0);
      send(make(REQ_MAIN, 7, 13'd3, 0, 1));
      send(make(REQ_TICK, 0, 0, 0, 1));

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_timeout(16'd3);
            1: set_timeout(16'd10);
            2: set_timeout(16'hFFFF);
            3: set_timeout(16'd2);
            4: set_timeout(16'd500);
            default: set_timeout(16'd6);
         endcase
         new_keys();
         steady = (phase == 3);
         for (int n = 0; n < 260; n++) begin
            if (phase == 1 && n == 130) drain();
            send(random_packet());
         end
      end
      steady = 0;

      drain();
      if (board.errors == 0) $display("[ipv4_fragment_tracker_unit] OK");
      else $display("[ipv4_fragment_tracker_unit] ERROR");
      $finish;
   end

   initial begin
      #40ms;
      $display("[ipv4_fragment_tracker_unit] ERROR");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ipv4ft_pkg.sv
rtl/core/ipv4ft_ram.sv
rtl/core/ipv4_fragment_tracker_unit.sv
rtl/core/ipv4ft_checker.sv
bench/testbench.sv
